// ===== hdl/rbb3_pkg.sv =====
// rbb3_pkg: shared constants, register codes and structs for the 3x3 box blur.
// No dependencies; compile first.
package rbb3_pkg;

    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;
    localparam int SIZE_RESET     = 1024;

    localparam int WORD_W      = 32;
    localparam int RGB_W       = 24;
    localparam int CHAN_W      = 8;
    localparam int CFG_DATA_W  = 11;
    localparam int CFG_INDEX_W = 1;

    // nine 8-bit samples sum to at most 2295
    localparam int SUM_W = 12;

    // x / 9 == (x * 7282) >> 16 for x < 2296
    localparam int DIV9_MUL   = 7282;
    localparam int DIV9_MUL_W = 13;
    localparam int DIV9_SHIFT = 16;

    localparam logic [CHAN_W-1:0] ALPHA_OPAQUE = 8'hFF;

    localparam int OUT_FIFO_DEPTH = 8;

    localparam logic CMD_DRAIN = 1'b1;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_LINE_WIDTH   = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } rbb3_reg_t;

    // per-word control, worked out at acceptance
    typedef struct packed {
        logic emit;
        logic last;
        logic top_edge;
        logic bottom_edge;
        logic left_edge;
        logic right_edge;
    } rbb3_ctrl_t;

    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic              last;
    } rbb3_result_t;

endpackage

// ===== hdl/rbb3_ifs.sv =====
// rbb3 channel interfaces: pixel input, blurred output and register write.
// Depends on rbb3_pkg.
interface rbb3_pix_if;
    import rbb3_pkg::*;
    logic              valid;
    logic              ready;
    logic              command;
    logic [WORD_W-1:0] pixel_word;
    modport source (output valid, command, pixel_word, input ready);
    modport sink   (input valid, command, pixel_word, output ready);
endinterface

interface rbb3_res_if;
    import rbb3_pkg::*;
    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] blurred_word;
    logic              last_of_frame;
    modport source (output valid, blurred_word, last_of_frame, input ready);
    modport sink   (input valid, blurred_word, last_of_frame, output ready);
endinterface

interface rbb3_cfg_if;
    import rbb3_pkg::*;
    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== hdl/rbb3_window.sv =====
// rbb3_window: two line stores (read-modify-write), 3x3 window taps, sum and /9.
// Depends on rbb3_pkg.
module rbb3_window #(
    parameter int MAX_WIDTH = rbb3_pkg::DEF_MAX_WIDTH
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           item_valid,
    input  logic [$clog2(MAX_WIDTH)-1:0]   item_col,
    input  logic [rbb3_pkg::RGB_W-1:0]     item_rgb,
    input  rbb3_pkg::rbb3_ctrl_t           item_ctrl,
    output logic                           res_valid,
    output rbb3_pkg::rbb3_result_t         res
);
    import rbb3_pkg::*;

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int PROD_W = SUM_W + DIV9_MUL_W;

    logic [RGB_W-1:0] upper_mem  [MAX_WIDTH];
    logic [RGB_W-1:0] middle_mem [MAX_WIDTH];

    logic [RGB_W-1:0] upper_rd_reg;
    logic [RGB_W-1:0] middle_rd_reg;

    logic             s1_valid_reg;
    logic [COL_W-1:0] s1_col_reg;
    logic [RGB_W-1:0] s1_rgb_reg;
    rbb3_ctrl_t       s1_ctrl_reg;

    logic             fwd_reg;
    logic [RGB_W-1:0] fwd_upper_reg;
    logic [RGB_W-1:0] fwd_middle_reg;

    logic [RGB_W-1:0] upper_col;
    logic [RGB_W-1:0] middle_col;

    logic [RGB_W-1:0] tap_reg [3][3];

    logic             s2_valid_reg;
    rbb3_ctrl_t       s2_ctrl_reg;
    logic [2:0]       row_ok;
    logic [2:0]       col_ok;
    logic [SUM_W-1:0] row_sum  [3][3];
    logic [SUM_W-1:0] sum_next [3];

    logic             s3_valid_reg;
    logic             s3_last_reg;
    logic [SUM_W-1:0] s3_sum_reg [3];
    logic [PROD_W-1:0] prod [3];
    logic [CHAN_W-1:0] quot [3];

    // line stores: read at acceptance, write back in the following cycle
    always_ff @(posedge clk)
    begin
        if (item_valid)
        begin
            upper_rd_reg  <= upper_mem[item_col];
            middle_rd_reg <= middle_mem[item_col];
        end
        if (s1_valid_reg)
        begin
            upper_mem[s1_col_reg]  <= middle_col;
            middle_mem[s1_col_reg] <= s1_rgb_reg;
        end
    end

    // same column read while it is being written (one-pixel lines, frame wrap)
    assign upper_col  = fwd_reg ? fwd_upper_reg  : upper_rd_reg;
    assign middle_col = fwd_reg ? fwd_middle_reg : middle_rd_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            fwd_reg      <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= item_valid;
            fwd_reg      <= item_valid && s1_valid_reg && (s1_col_reg == item_col);
            s2_valid_reg <= s1_valid_reg && s1_ctrl_reg.emit;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid)
        begin
            s1_col_reg     <= item_col;
            s1_rgb_reg     <= item_rgb;
            s1_ctrl_reg    <= item_ctrl;
            fwd_upper_reg  <= middle_col;
            fwd_middle_reg <= s1_rgb_reg;
        end
        if (s1_valid_reg)
        begin
            s2_ctrl_reg <= s1_ctrl_reg;
        end
        if (s2_valid_reg)
        begin
            s3_sum_reg  <= sum_next;
            s3_last_reg <= s2_ctrl_reg.last;
        end
    end

    // window taps: column 2 is the newest
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < 3; r++)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    tap_reg[r][c] <= '0;
                end
            end
        end
        else if (s1_valid_reg)
        begin
            for (int r = 0; r < 3; r++)
            begin
                tap_reg[r][0] <= tap_reg[r][1];
                tap_reg[r][1] <= tap_reg[r][2];
            end
            tap_reg[0][2] <= upper_col;
            tap_reg[1][2] <= middle_col;
            tap_reg[2][2] <= s1_rgb_reg;
        end
    end

    assign row_ok = {!s2_ctrl_reg.bottom_edge, 1'b1, !s2_ctrl_reg.top_edge};
    assign col_ok = {!s2_ctrl_reg.right_edge, 1'b1, !s2_ctrl_reg.left_edge};

    // out-of-frame samples add nothing
    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            for (int ch = 0; ch < 3; ch++)
            begin
                row_sum[r][ch] = '0;
                for (int c = 0; c < 3; c++)
                begin
                    if (row_ok[r] && col_ok[c])
                    begin
                        row_sum[r][ch] = row_sum[r][ch]
                            + SUM_W'(tap_reg[r][c][RGB_W-1-ch*CHAN_W -: CHAN_W]);
                    end
                end
            end
        end
        for (int ch = 0; ch < 3; ch++)
        begin
            sum_next[ch] = row_sum[0][ch] + row_sum[1][ch] + row_sum[2][ch];
        end
    end

    always_comb
    begin
        for (int ch = 0; ch < 3; ch++)
        begin
            prod[ch] = PROD_W'(s3_sum_reg[ch]) * PROD_W'(DIV9_MUL);
            quot[ch] = prod[ch][DIV9_SHIFT +: CHAN_W];
        end
    end

    assign res_valid = s3_valid_reg;
    assign res.word  = {quot[0], quot[1], quot[2], ALPHA_OPAQUE};
    assign res.last  = s3_last_reg;

endmodule

// ===== hdl/rbb3_out_fifo.sv =====
// rbb3_out_fifo: small result queue that decouples the pipeline from the receiver.
// Depends on rbb3_pkg.
module rbb3_out_fifo #(
    parameter int DEPTH = rbb3_pkg::OUT_FIFO_DEPTH
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  rbb3_pkg::rbb3_result_t push_data,
    input  logic                   pop,
    output logic                   out_valid,
    output rbb3_pkg::rbb3_result_t out_data
);
    import rbb3_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    rbb3_result_t     fifo_mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_mem[wr_ptr_reg] <= push_data;
        end
    end

    assign out_valid = (count_reg != '0);
    assign out_data  = fifo_mem[rd_ptr_reg];

endmodule

// ===== hdl/rgb_box_blur_3x3_unit.sv =====
// rgb_box_blur_3x3_unit: top level of the 3x3 box blur over a raster pixel stream.
// Depends on rbb3_pkg, rbb3_ifs, rbb3_window and rbb3_out_fifo.
//
// Usage
//   pixels  : RGBA8888 words of a frame in raster order; command marks drain words.
//             After line_width*frame_height pixels, send line_width+1 drain words.
//   blurred : one blurred word per pixel, raster order, alpha byte 0xFF;
//             last_of_frame flags pixel (H-1, W-1), after which a new frame starts.
//   cfg     : index 0 line_width, index 1 frame_height; 0 reads as 1, values
//             above the maximum saturate. A write restarts the frame. Always ready;
//             write only while idle.
// Timing
//   Result for pixel (r,c) is produced by the word at (r+1,c+1), or (r+2,0) for
//   the last column. It reaches blurred via stages s1, s2, s3 and the queue.
//   Throughput: one word per cycle while not stalled, set by one read-modify-write
//   access per cycle to the two line stores (one read, one write port each).
// Reset
//   Positions return to the frame start, sizes to 1024 (or the maximum). The line
//   stores are not cleared; only entries written in the current frame are used.
// Backpressure
//   Results queue in an 8-deep output queue; pixels.ready drops only when every
//   queue slot is spoken for by words in flight, so the input side keeps moving
//   while a finished result waits to be taken.
module rgb_box_blur_3x3_unit #(
    parameter int MAX_WIDTH  = rbb3_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = rbb3_pkg::DEF_MAX_HEIGHT
) (
    input  logic         clk,
    input  logic         rst_n,
    rbb3_pix_if.sink     pixels,
    rbb3_res_if.source   blurred,
    rbb3_cfg_if.sink     cfg
);
    import rbb3_pkg::*;

    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int WW        = $clog2(MAX_WIDTH + 1);
    localparam int HW        = $clog2(MAX_HEIGHT + 1);
    localparam int IN_ROW_W  = $clog2(MAX_HEIGHT + 2);   // drain rows run to H+1
    localparam int OUT_ROW_W = $clog2(MAX_HEIGHT);
    localparam int CREDIT_W  = $clog2(OUT_FIFO_DEPTH + 1);

    localparam logic [WW-1:0] WIDTH_RESET =
        WW'(SIZE_RESET > MAX_WIDTH ? MAX_WIDTH : SIZE_RESET);
    localparam logic [HW-1:0] HEIGHT_RESET =
        HW'(SIZE_RESET > MAX_HEIGHT ? MAX_HEIGHT : SIZE_RESET);

    // configuration
    logic [WW-1:0]        line_width_reg,   line_width_next;
    logic [HW-1:0]        frame_height_reg, frame_height_next;
    logic [WW-1:0]        cfg_width;
    logic [HW-1:0]        cfg_height;

    // raster positions of the next input word and the next result
    logic [COL_W-1:0]     in_col_reg,  in_col_next;
    logic [IN_ROW_W-1:0]  in_row_reg,  in_row_next;
    logic [COL_W-1:0]     out_col_reg, out_col_next;
    logic [OUT_ROW_W-1:0] out_row_reg, out_row_next;

    // results owed: in the pipeline or in the output queue
    logic [CREDIT_W-1:0]  credit_reg, credit_next;

    logic                 in_acc;
    logic                 out_acc;
    logic                 cfg_wr;
    logic                 emit;
    logic                 in_col_end;
    logic                 out_col_end;
    logic                 out_row_end;
    logic                 frame_end;
    rbb3_ctrl_t           item_ctrl;
    logic [RGB_W-1:0]     item_rgb;

    logic                 res_valid;
    rbb3_result_t         res;
    rbb3_result_t         queue_head;

    assign in_acc  = pixels.valid && pixels.ready;
    assign out_acc = blurred.valid && blurred.ready;
    assign cfg_wr  = cfg.valid && cfg.ready;

    assign pixels.ready = (credit_reg < CREDIT_W'(OUT_FIFO_DEPTH));
    assign cfg.ready    = 1'b1;

    // register write clamping: zero -> 1, above the maximum -> maximum
    always_comb
    begin
        if (cfg.data == '0)
        begin
            cfg_width = WW'(1);
        end
        else if (32'(cfg.data) > MAX_WIDTH)
        begin
            cfg_width = WW'(MAX_WIDTH);
        end
        else
        begin
            cfg_width = WW'(cfg.data);
        end

        if (cfg.data == '0)
        begin
            cfg_height = HW'(1);
        end
        else if (32'(cfg.data) > MAX_HEIGHT)
        begin
            cfg_height = HW'(MAX_HEIGHT);
        end
        else
        begin
            cfg_height = HW'(cfg.data);
        end
    end

    // a result is due once the stream has passed one line and one pixel
    assign emit = (in_row_reg >= IN_ROW_W'(2))
               || ((in_row_reg == IN_ROW_W'(1)) && (in_col_reg != '0));

    assign in_col_end  = (WW'(in_col_reg) == line_width_reg - 1'b1);
    assign out_col_end = (WW'(out_col_reg) == line_width_reg - 1'b1);
    assign out_row_end = (HW'(out_row_reg) == frame_height_reg - 1'b1);
    assign frame_end   = emit && out_row_end && out_col_end;

    // edge flags for the result this word completes
    assign item_ctrl.emit        = emit;
    assign item_ctrl.last        = frame_end;
    assign item_ctrl.top_edge    = (out_row_reg == '0);
    assign item_ctrl.bottom_edge = out_row_end;
    assign item_ctrl.left_edge   = (out_col_reg == '0);
    assign item_ctrl.right_edge  = out_col_end;

    // drain words stand for black pixels
    assign item_rgb = (pixels.command == CMD_DRAIN) ? '0 : pixels.pixel_word[WORD_W-1 -: RGB_W];

    always_comb
    begin
        line_width_next   = line_width_reg;
        frame_height_next = frame_height_reg;
        in_col_next       = in_col_reg;
        in_row_next       = in_row_reg;
        out_col_next      = out_col_reg;
        out_row_next      = out_row_reg;

        if (cfg_wr)
        begin
            case (cfg.index)
                REG_LINE_WIDTH:   line_width_next   = cfg_width;
                REG_FRAME_HEIGHT: frame_height_next = cfg_height;
                default:          line_width_next   = line_width_reg;
            endcase
            in_col_next  = '0;
            in_row_next  = '0;
            out_col_next = '0;
            out_row_next = '0;
        end
        else if (in_acc)
        begin
            if (frame_end)
            begin
                in_col_next  = '0;
                in_row_next  = '0;
                out_col_next = '0;
                out_row_next = '0;
            end
            else
            begin
                if (emit)
                begin
                    if (out_col_end)
                    begin
                        out_col_next = '0;
                        out_row_next = out_row_reg + 1'b1;
                    end
                    else
                    begin
                        out_col_next = out_col_reg + 1'b1;
                    end
                end
                if (in_col_end)
                begin
                    in_col_next = '0;
                    in_row_next = in_row_reg + 1'b1;
                end
                else
                begin
                    in_col_next = in_col_reg + 1'b1;
                end
            end
        end
    end

    always_comb
    begin
        credit_next = credit_reg;
        if (in_acc && emit && !out_acc)
        begin
            credit_next = credit_reg + 1'b1;
        end
        else if (!(in_acc && emit) && out_acc)
        begin
            credit_next = credit_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_width_reg   <= WIDTH_RESET;
            frame_height_reg <= HEIGHT_RESET;
            in_col_reg       <= '0;
            in_row_reg       <= '0;
            out_col_reg      <= '0;
            out_row_reg      <= '0;
            credit_reg       <= '0;
        end
        else
        begin
            line_width_reg   <= line_width_next;
            frame_height_reg <= frame_height_next;
            in_col_reg       <= in_col_next;
            in_row_reg       <= in_row_next;
            out_col_reg      <= out_col_next;
            out_row_reg      <= out_row_next;
            credit_reg       <= credit_next;
        end
    end

    rbb3_window #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_window (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (in_acc),
        .item_col   (in_col_reg),
        .item_rgb   (item_rgb),
        .item_ctrl  (item_ctrl),
        .res_valid  (res_valid),
        .res        (res)
    );

    rbb3_out_fifo #(
        .DEPTH (OUT_FIFO_DEPTH)
    ) u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_valid),
        .push_data (res),
        .pop       (out_acc),
        .out_valid (blurred.valid),
        .out_data  (queue_head)
    );

    assign blurred.blurred_word  = queue_head.word;
    assign blurred.last_of_frame = queue_head.last;

endmodule

// ===== hdl/rbb3_checker.sv =====
// rbb3_checker: port-level assertions for rgb_box_blur_3x3_unit, bound to the top level.
// Depends on rbb3_pkg and rgb_box_blur_3x3_unit.
module rbb3_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_ready,
    input logic                        out_valid,
    input logic                        out_ready,
    input logic [rbb3_pkg::WORD_W-1:0] out_word,
    input logic                        out_last
);
    logic in_acc;

    assign in_acc = in_valid && in_ready;

    // stalled word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_word) && $stable(out_last))
        else $error("blurred word changed or dropped while stalled");

    // no result without a word accepted in the pipeline window
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid && !in_acc && !$past(in_acc) && !$past(in_acc, 2) && !$past(in_acc, 3)
        |=> !out_valid)
        else $error("result appeared with nothing in flight");

    // nothing owed and queue empty: input must be open
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid && !$past(in_acc) && !$past(in_acc, 2) && !$past(in_acc, 3)
        && !$past(in_acc, 4) |-> in_ready)
        else $error("input blocked with pipeline and queue empty");

endmodule

bind rgb_box_blur_3x3_unit rbb3_checker u_rbb3_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (pixels.valid),
    .in_ready  (pixels.ready),
    .out_valid (blurred.valid),
    .out_ready (blurred.ready),
    .out_word  (blurred.blurred_word),
    .out_last  (blurred.last_of_frame)
);
